// File: rtl/cscan_disk_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// cscan_disk_scheduler_top_macros.svh
// assertion shorthands for the c-scan disk scheduler
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_SCHEDULER_TOP_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define CSCAN_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CSCAN_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cscan_pkg.sv
// ----------------------------------------------------------------------------
// cscan_pkg
// types and constants shared by the c-scan disk scheduler modules
// ----------------------------------------------------------------------------
package cscan_pkg;

   localparam int CYL_BITS     = 16;
   localparam int SIZE_BITS    = 17;
   localparam int SEEK_BITS    = 18;
   localparam int ERR_BITS     = 2;
   localparam int CSR_IDX_BITS = 2;

   // error code bit positions
   localparam int ERR_OVERFLOW_BIT = 0;
   localparam int ERR_RANGE_BIT    = 1;

   localparam logic [SIZE_BITS-1:0] DISK_SIZE_MAX   = SIZE_BITS'(1) << CYL_BITS;
   localparam logic [SIZE_BITS-1:0] DISK_SIZE_RESET = DISK_SIZE_MAX;

   // result kinds
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_TOTAL   = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_HEAD      = 2'd0,
      CSR_SWEEP_DIRECTION = 2'd1,
      CSR_DISK_SIZE       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CYL_BITS-1:0] cylinder;
      logic                batch_end;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [CYL_BITS-1:0]  served_cylinder;
      logic [SEEK_BITS-1:0] seek_so_far;
      logic                 last_result;
      logic [ERR_BITS-1:0]  error_code;
   } rsp_type;

   // batch setup handed from the loader to the sequencer
   typedef struct packed {
      logic [CYL_BITS-1:0] head;
      logic [CYL_BITS-1:0] top_cyl;
      logic                dir;
      logic [ERR_BITS-1:0] err;
   } job_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_WRAP,
      SEQ_MOVE,
      SEQ_TOTAL
   } seq_state_type;

endpackage

// File: rtl/cscan_req_mem.sv
// ----------------------------------------------------------------------------
// cscan_req_mem
// request store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cscan_req_mem #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cscan_seq.sv
// ----------------------------------------------------------------------------
// cscan_seq
// service order sequencer: one pass over the store per result picks the
// next request by wrapped key, then tracks head position and seek distance
// ----------------------------------------------------------------------------
module cscan_seq #(
   parameter int MAX_REQUESTS = 32,
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [CNT_W-1:0]                     start_count,
   input  cscan_pkg::job_type                   job,
   output logic                                 busy,
   output logic                                 rd_en,
   output logic [IDX_W-1:0]                     rd_addr,
   input  logic [cscan_pkg::CYL_BITS-1:0]       rd_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cscan_pkg::rsp_type                   rsp_data
);

   localparam int CB    = cscan_pkg::CYL_BITS;
   localparam int SB    = cscan_pkg::SEEK_BITS;
   localparam int KEY_W = 1 + CB + IDX_W;

   cscan_pkg::seq_state_type state_ff, state_in;

   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              addr_ff, addr_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [cscan_pkg::ERR_BITS-1:0] err_ff, err_in;
   logic [CB-1:0]                 head_ff, head_in;
   logic [CB-1:0]                 top_ff, top_in;
   logic                          dir_ff, dir_in;
   logic [CB-1:0]                 cur_ff, cur_in;
   logic [SB-1:0]                 seek_ff, seek_in;
   logic                          wrapped_ff, wrapped_in;
   logic                          have_last_ff, have_last_in;
   logic [KEY_W-1:0]              last_key_ff, last_key_in;
   logic                          best_valid_ff, best_valid_in;
   logic [KEY_W-1:0]              best_key_ff, best_key_in;
   logic                          rsp_valid_ff;
   cscan_pkg::rsp_type            rsp_data_ff;

   logic                          issue;
   logic                          out_free;
   logic                          out_load;
   cscan_pkg::rsp_type            out_data;
   logic                          rd_oor;
   logic                          rd_grp;
   logic [CB-1:0]                 rd_vv;
   logic [KEY_W-1:0]              rd_key;
   logic                          cand;
   logic [CB-1:0]                 best_cyl;
   logic [CB-1:0]                 move_dist;
   logic [SB-1:0]                 move_seek;
   logic [SB-1:0]                 wrap_dist;

   // wrapped key: group first, then cylinder (inverted when sweeping down), then slot
   assign rd_oor = rd_data > top_ff;
   assign rd_grp = dir_ff ? (rd_data > head_ff) : (rd_data <= head_ff);
   assign rd_vv  = dir_ff ? ~rd_data : rd_data;
   assign rd_key = {rd_grp, rd_vv, rd_idx_ff};
   assign cand   = (!have_last_ff || (rd_key > last_key_ff)) &&
                   (!best_valid_ff || (rd_key < best_key_ff));

   // head movement for the picked request and for the sweep plus wrap jump
   assign best_cyl  = dir_ff ? ~best_key_ff[CB+IDX_W-1:IDX_W] : best_key_ff[CB+IDX_W-1:IDX_W];
   assign move_dist = (cur_ff > best_cyl) ? (cur_ff - best_cyl) : (best_cyl - cur_ff);
   assign move_seek = seek_ff + SB'(move_dist);
   assign wrap_dist = dir_ff ? (SB'(cur_ff) + SB'(top_ff))
                             : (SB'(top_ff - cur_ff) + SB'(top_ff));

   assign issue    = addr_ff < cnt_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cscan_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      err_in        = err_ff;
      head_in       = head_ff;
      top_in        = top_ff;
      dir_in        = dir_ff;
      cur_in        = cur_ff;
      seek_in       = seek_ff;
      wrapped_in    = wrapped_ff;
      have_last_in  = have_last_ff;
      last_key_in   = last_key_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      out_data      = '0;

      unique case (state_ff)
         cscan_pkg::SEQ_IDLE: begin
            if (start) begin
               cnt_in        = start_count;
               err_in        = job.err;
               head_in       = job.head;
               top_in        = job.top_cyl;
               dir_in        = job.dir;
               cur_in        = job.head;
               seek_in       = '0;
               wrapped_in    = 1'b0;
               have_last_in  = 1'b0;
               best_valid_in = 1'b0;
               addr_in       = '0;
               state_in      = cscan_pkg::SEQ_SCAN;
            end
         end
         cscan_pkg::SEQ_SCAN: begin
            // stream the store, keep the smallest key above the last one served
            rd_en     = issue;
            rd_vld_in = issue;
            rd_idx_in = addr_ff[IDX_W-1:0];
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (rd_oor) begin
                  err_in[cscan_pkg::ERR_RANGE_BIT] = 1'b1;
               end else if (cand) begin
                  best_valid_in = 1'b1;
                  best_key_in   = rd_key;
               end
            end
            if (!issue && !rd_vld_ff) begin
               if (best_valid_ff) begin
                  have_last_in = 1'b1;
                  last_key_in  = best_key_ff;
                  state_in     = (best_key_ff[KEY_W-1] && !wrapped_ff) ?
                                 cscan_pkg::SEQ_WRAP : cscan_pkg::SEQ_MOVE;
               end else begin
                  state_in = wrapped_ff ? cscan_pkg::SEQ_TOTAL : cscan_pkg::SEQ_WRAP;
               end
            end
         end
         cscan_pkg::SEQ_WRAP: begin
            // run to the disk edge and jump to the far end
            seek_in    = seek_ff + wrap_dist;
            cur_in     = dir_ff ? top_ff : '0;
            wrapped_in = 1'b1;
            state_in   = best_valid_ff ? cscan_pkg::SEQ_MOVE : cscan_pkg::SEQ_TOTAL;
         end
         cscan_pkg::SEQ_MOVE: begin
            if (out_free) begin
               out_load                 = 1'b1;
               out_data.kind            = cscan_pkg::KIND_REQUEST;
               out_data.served_cylinder = best_cyl;
               out_data.seek_so_far     = move_seek;
               out_data.last_result     = 1'b0;
               out_data.error_code      = err_ff;
               seek_in                  = move_seek;
               cur_in                   = best_cyl;
               addr_in                  = '0;
               best_valid_in            = 1'b0;
               state_in                 = cscan_pkg::SEQ_SCAN;
            end
         end
         cscan_pkg::SEQ_TOTAL: begin
            if (out_free) begin
               out_load                 = 1'b1;
               out_data.kind            = cscan_pkg::KIND_TOTAL;
               out_data.served_cylinder = '0;
               out_data.seek_so_far     = seek_ff;
               out_data.last_result     = 1'b1;
               out_data.error_code      = err_ff;
               state_in                 = cscan_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = cscan_pkg::SEQ_IDLE;
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
      cnt_ff        <= cnt_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      err_ff        <= err_in;
      head_ff       <= head_in;
      top_ff        <= top_in;
      dir_ff        <= dir_in;
      cur_ff        <= cur_in;
      seek_ff       <= seek_in;
      wrapped_ff    <= wrapped_in;
      have_last_ff  <= have_last_in;
      last_key_ff   <= last_key_in;
      best_valid_ff <= best_valid_in;
      best_key_ff   <= best_key_in;
   end

   // result register, frees the sequencer from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   assign busy      = state_ff != cscan_pkg::SEQ_IDLE;
   assign rd_addr   = addr_ff[IDX_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/cscan_disk_scheduler_top.sv
// ----------------------------------------------------------------------------
// cscan_disk_scheduler_top
// C-SCAN disk scheduler. Requests load one beat per cycle into a request
// store; the beat with batch_end closes the batch. The block then stalls
// its request side and emits the kept requests in C-SCAN order, one
// result per pass over the store, followed by a total beat. Each pass reads
// every stored request through the single read port of the request
// store; the picked request is then emitted, and the sweep and wrap jump
// and the total beat are steps of their own. A stalled result holds the
// sequencer for the length of the stall.
// Register writes are taken only while the block is idle.
// ----------------------------------------------------------------------------
`include "cscan_disk_scheduler_top_macros.svh"

module cscan_disk_scheduler_top #(
   parameter int MAX_REQUESTS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  cscan_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output cscan_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cscan_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [cscan_pkg::SIZE_BITS-1:0]        csr_wdata
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int CB    = cscan_pkg::CYL_BITS;
   localparam int ZB    = cscan_pkg::SIZE_BITS;

   logic [CB-1:0]                  start_head_ff;
   logic                           sweep_dir_ff;
   logic [ZB-1:0]                  disk_size_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [cscan_pkg::ERR_BITS-1:0] err_ff;

   logic [ZB-1:0]                  eff_size;
   logic [CB-1:0]                  top_cyl;
   logic [CB-1:0]                  head_clamp;
   logic                           seq_busy;
   logic                           req_accept;
   logic                           in_range;
   logic                           has_room;
   logic                           store;
   logic                           start;
   logic [CNT_W-1:0]               count_in;
   logic [cscan_pkg::ERR_BITS-1:0] err_in;
   cscan_pkg::job_type             job;
   logic                           rd_en;
   logic [IDX_W-1:0]               rd_addr;
   logic [CB-1:0]                  rd_data;

   // disk geometry from the registers
   always_comb begin
      if (disk_size_ff == '0) begin
         eff_size = ZB'(1);
      end else if (disk_size_ff > cscan_pkg::DISK_SIZE_MAX) begin
         eff_size = cscan_pkg::DISK_SIZE_MAX;
      end else begin
         eff_size = disk_size_ff;
      end
   end
   assign top_cyl    = CB'(eff_size - ZB'(1));
   assign head_clamp = (start_head_ff > top_cyl) ? top_cyl : start_head_ff;

   // register writes
   assign csr_ready = !seq_busy;
   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= '0;
         sweep_dir_ff  <= 1'b0;
         disk_size_ff  <= cscan_pkg::DISK_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cscan_pkg::CSR_START_HEAD:      start_head_ff <= csr_wdata[CB-1:0];
            cscan_pkg::CSR_SWEEP_DIRECTION: sweep_dir_ff  <= csr_wdata[0];
            cscan_pkg::CSR_DISK_SIZE:       disk_size_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request loading: range check first, then store room
   assign req_stall  = seq_busy;
   assign req_accept = req_valid && !req_stall;
   assign in_range   = req_data.cylinder <= top_cyl;
   assign has_room   = count_ff < CNT_W'(MAX_REQUESTS);
   assign store      = req_accept && in_range && has_room;
   assign start      = req_accept && req_data.batch_end;
   assign count_in   = count_ff + CNT_W'(store);

   always_comb begin
      err_in = err_ff;
      if (req_accept && !in_range) begin
         err_in[cscan_pkg::ERR_RANGE_BIT] = 1'b1;
      end
      if (req_accept && in_range && !has_room) begin
         err_in[cscan_pkg::ERR_OVERFLOW_BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= '0;
      end else if (start) begin
         count_ff <= '0;
         err_ff   <= '0;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // batch setup for the sequencer
   assign job.head    = head_clamp;
   assign job.top_cyl = top_cyl;
   assign job.dir     = sweep_dir_ff;
   assign job.err     = err_in;

   cscan_req_mem #(
      .DEPTH  (MAX_REQUESTS),
      .DATA_W (CB)
   ) u_mem (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.cylinder),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cscan_seq #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_count (count_in),
      .job         (job),
      .busy        (seq_busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // checks
   `CSCAN_CHECK(a_count_clear_while_busy, seq_busy, count_ff == '0,
      "store count not cleared during scheduling")
   `CSCAN_CHECK_NEXT(a_batch_end_starts, req_accept && req_data.batch_end, seq_busy,
      "batch close did not start scheduling")
   `CSCAN_CHECK(a_total_beat_fields,
      rsp_valid && (rsp_data.kind == cscan_pkg::KIND_TOTAL),
      rsp_data.last_result && (rsp_data.served_cylinder == '0),
      "malformed total beat")

endmodule
